// ===== hdl/bcsc_pkg.sv =====
// Shared types, status codes and the battery class table for the charger status controller.
`default_nettype none

package bcsc_pkg;

    localparam int CLASS_COUNT = 5;
    localparam int TABLE_ROWS  = 5;
    localparam int SEARCH_ROWS = (CLASS_COUNT < TABLE_ROWS) ? CLASS_COUNT : TABLE_ROWS;

    localparam int VOLT_W  = 10;
    localparam int USB_W   = 8;
    localparam int CLASS_W = 3;

    localparam logic [CLASS_W-1:0] CLASS_UNKNOWN = 3'd5;

    // Voltage limits in 0.1 V units.
    localparam logic [VOLT_W-1:0]  BAT_MIN_VOLT   = 10'd10;
    localparam logic [VOLT_W-1:0]  RAIL_24V_VOLT  = 10'd360;
    localparam logic [USB_W-1:0]   USB_THRESHOLD  = 8'd10;
    localparam logic [VOLT_W:0]    CLASS_MARGIN   = 11'd5;

    typedef enum logic [1:0] {
        BS_NORMAL  = 2'd0,
        BS_REVERSE = 2'd1,
        BS_ERROR   = 2'd2,
        BS_UNSEEN  = 2'd3
    } bat_status_t;

    typedef enum logic [2:0] {
        IS_CHARGE = 3'd0,
        IS_FIX    = 3'd1,
        IS_NONE   = 3'd2,
        IS_OVER   = 3'd3,
        IS_UNSEEN = 3'd4
    } in_status_t;

    typedef enum logic [1:0] {
        USB_IDLE    = 2'd0,
        USB_ONE_AMP = 2'd1,
        USB_TWO_AMP = 2'd2
    } usb_status_t;

    typedef struct packed {
        logic [VOLT_W-1:0] low;
        logic [VOLT_W-1:0] high;
        logic [VOLT_W-1:0] nominal;
        logic [VOLT_W-1:0] max_err;
    } class_row_t;

    typedef struct packed {
        logic [VOLT_W-1:0] battery_voltage;
        logic [VOLT_W-1:0] input_voltage;
        logic [USB_W-1:0]  usb_current;
        logic              reverse_connected;
        logic              supply_24v_present;
    } item_t;

    typedef struct packed {
        logic [CLASS_W-1:0] latched_class;
        bat_status_t        last_bs;
        in_status_t         last_is;
        logic               relay;
        logic               rail_24v;
        logic               full_seen;
    } state_t;

    typedef struct packed {
        bat_status_t        battery_status;
        in_status_t         input_status;
        usb_status_t        usb_status;
        logic [CLASS_W-1:0] battery_class;
        logic               relay_on;
        logic               supply_from_24v;
        logic               charge_full_start;
    } result_t;

    function automatic class_row_t class_row(input logic [CLASS_W-1:0] idx);
        class_row_t row;
        case (idx)
            3'd0:    row = '{10'd48,  10'd72,  10'd55,  10'd73};
            3'd1:    row = '{10'd96,  10'd143, 10'd114, 10'd145};
            3'd2:    row = '{10'd192, 10'd286, 10'd228, 10'd290};
            3'd3:    row = '{10'd288, 10'd432, 10'd331, 10'd438};
            3'd4:    row = '{10'd440, 10'd576, 10'd441, 10'd584};
            default: row = '0;
        endcase
        return row;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bcsc_eval.sv =====
// Combinational evaluation of one measurement beat against the controller state.
`default_nettype none

module bcsc_eval (
    input  wire bcsc_pkg::item_t   item,
    input  wire bcsc_pkg::state_t  cur,
    output bcsc_pkg::state_t       nxt,
    output bcsc_pkg::result_t      res
);

    logic [bcsc_pkg::SEARCH_ROWS-1:0] row_hit;
    bcsc_pkg::class_row_t             srch_row;
    logic [bcsc_pkg::CLASS_W-1:0]     found_class;
    logic                             known_cur;
    logic                             known_next;
    logic [bcsc_pkg::CLASS_W-1:0]     class_next;
    bcsc_pkg::class_row_t             cur_row;
    bcsc_pkg::class_row_t             next_row;
    bcsc_pkg::bat_status_t            bs;
    bcsc_pkg::in_status_t             is;
    bcsc_pkg::usb_status_t            us;
    logic                             relay;
    logic                             rail;
    logic                             pulse;

    // Window compare against every searchable row in parallel.
    always_comb
    begin
        srch_row = '0;
        for (int i = 0; i < bcsc_pkg::SEARCH_ROWS; i++)
        begin
            srch_row   = bcsc_pkg::class_row(i[bcsc_pkg::CLASS_W-1:0]);
            row_hit[i] = (item.battery_voltage >= srch_row.low)
                && ({1'b0, item.battery_voltage} <=
                    ({1'b0, srch_row.high} + bcsc_pkg::CLASS_MARGIN));
        end
    end

    // First matching row wins.
    always_comb
    begin
        found_class = bcsc_pkg::CLASS_UNKNOWN;
        for (int i = bcsc_pkg::SEARCH_ROWS - 1; i >= 0; i--)
        begin
            if (row_hit[i])
            begin
                found_class = i[bcsc_pkg::CLASS_W-1:0];
            end
        end
    end

    assign known_cur = ({1'b0, cur.latched_class} < (bcsc_pkg::CLASS_W + 1)'(bcsc_pkg::SEARCH_ROWS));
    assign cur_row   = bcsc_pkg::class_row(cur.latched_class);

    always_comb
    begin
        class_next = cur.latched_class;
        if (item.reverse_connected)
        begin
            bs = bcsc_pkg::BS_REVERSE;
        end
        else if (item.battery_voltage < bcsc_pkg::BAT_MIN_VOLT)
        begin
            bs = bcsc_pkg::BS_ERROR;
        end
        else if (!known_cur)
        begin
            class_next = found_class;
            bs = (found_class != bcsc_pkg::CLASS_UNKNOWN) ? bcsc_pkg::BS_NORMAL
                                                           : bcsc_pkg::BS_ERROR;
        end
        else if (item.battery_voltage >= cur_row.low && item.battery_voltage <= cur_row.high)
        begin
            bs = bcsc_pkg::BS_NORMAL;
        end
        else
        begin
            bs = bcsc_pkg::BS_ERROR;
        end
    end

    assign known_next = ({1'b0, class_next} < (bcsc_pkg::CLASS_W + 1)'(bcsc_pkg::SEARCH_ROWS));
    assign next_row   = bcsc_pkg::class_row(class_next);

    always_comb
    begin
        if (!known_next || bs != bcsc_pkg::BS_NORMAL)
        begin
            is = bcsc_pkg::IS_NONE;
        end
        else if (item.supply_24v_present && item.input_voltage <= next_row.max_err
                 && item.input_voltage >= next_row.nominal)
        begin
            is = (item.battery_voltage < next_row.nominal) ? bcsc_pkg::IS_FIX
                                                            : bcsc_pkg::IS_CHARGE;
        end
        else if (item.input_voltage > next_row.max_err)
        begin
            is = bcsc_pkg::IS_OVER;
        end
        else
        begin
            is = bcsc_pkg::IS_NONE;
        end
    end

    always_comb
    begin
        if (item.usb_current != '0 && item.usb_current < bcsc_pkg::USB_THRESHOLD)
        begin
            us = bcsc_pkg::USB_ONE_AMP;
        end
        else if (item.usb_current > bcsc_pkg::USB_THRESHOLD)
        begin
            us = bcsc_pkg::USB_TWO_AMP;
        end
        else
        begin
            us = bcsc_pkg::USB_IDLE;
        end
    end

    // Relay acts only on status changes; the input status change has the last word.
    always_comb
    begin
        relay = cur.relay;
        if (bs != cur.last_bs && bs != bcsc_pkg::BS_NORMAL)
        begin
            relay = 1'b0;
        end
        if (is != cur.last_is)
        begin
            relay = (is == bcsc_pkg::IS_CHARGE) || (is == bcsc_pkg::IS_FIX);
        end
    end

    always_comb
    begin
        rail = cur.rail_24v;
        if (item.battery_voltage >= bcsc_pkg::RAIL_24V_VOLT || item.supply_24v_present)
        begin
            rail = 1'b1;
        end
        if (us == bcsc_pkg::USB_TWO_AMP && bs == bcsc_pkg::BS_NORMAL)
        begin
            rail = 1'b0;
        end
    end

    assign pulse = known_next && !cur.full_seen && (item.input_voltage >= next_row.high);

    always_comb
    begin
        nxt.latched_class = class_next;
        nxt.last_bs       = bs;
        nxt.last_is       = is;
        nxt.relay         = relay;
        nxt.rail_24v      = rail;
        nxt.full_seen     = cur.full_seen | pulse;

        res.battery_status    = bs;
        res.input_status      = is;
        res.usb_status        = us;
        res.battery_class     = class_next;
        res.relay_on          = relay;
        res.supply_from_24v   = rail;
        res.charge_full_start = pulse;
    end

endmodule

`default_nettype wire

// ===== hdl/battery_charger_status_controller.sv =====
// Top level of the battery charger status controller: beat registers, state and checks.
//
//   Channel   Direction  Handshake            Payload
//   input     in         in_valid / in_ready  battery_voltage, input_voltage, usb_current,
//                                             reverse_connected, supply_24v_present
//   output    out        out_valid/out_ready  battery_status, input_status, usb_status,
//                                             battery_class, relay_on, supply_from_24v,
//                                             charge_full_start
//
// One beat is accepted per clock cycle when the output side keeps taking results.
// An accepted beat is evaluated from the input register, and its result and the state
// update are loaded into the result and state registers when the beat advances.
// While a result waits on out_ready, one more beat can still be captured; after that
// in_ready stays low until the waiting result is taken.
// Reset clears the valid flags and the controller state (class unknown, no status seen,
// relay off, rail from battery, full pulse not yet given).
`default_nettype none

module battery_charger_status_controller (
    input  wire        clk,
    input  wire        rst_n,

    input  wire        in_valid,
    output logic       in_ready,
    input  wire [9:0]  battery_voltage,
    input  wire [9:0]  input_voltage,
    input  wire [7:0]  usb_current,
    input  wire        reverse_connected,
    input  wire        supply_24v_present,

    output logic       out_valid,
    input  wire        out_ready,
    output logic [1:0] battery_status,
    output logic [1:0] input_status,
    output logic [1:0] usb_status,
    output logic [2:0] battery_class,
    output logic       relay_on,
    output logic       supply_from_24v,
    output logic       charge_full_start
);

    // Input register holding the accepted measurement beat.
    logic               in_vld_reg;
    bcsc_pkg::item_t    item_reg;

    // Result register.
    logic               out_vld_reg;
    bcsc_pkg::result_t  res_reg;

    // Controller state carried from beat to beat.
    bcsc_pkg::state_t   state_reg;
    bcsc_pkg::state_t   state_next;
    bcsc_pkg::result_t  res_next;

    logic               advance;
    logic               take_in;

    // A held beat moves on when the result register is empty or is being emptied.
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;
    assign take_in  = in_valid && in_ready;

    bcsc_eval u_eval (
        .item (item_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= '{latched_class: bcsc_pkg::CLASS_UNKNOWN,
                             last_bs:       bcsc_pkg::BS_UNSEEN,
                             last_is:       bcsc_pkg::IS_UNSEEN,
                             relay:         1'b0,
                             rail_24v:      1'b0,
                             full_seen:     1'b0};
        end
        else
        begin
            if (take_in)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end

            if (advance)
            begin
                out_vld_reg <= 1'b1;
                state_reg   <= state_next;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            item_reg.battery_voltage    <= battery_voltage;
            item_reg.input_voltage      <= input_voltage;
            item_reg.usb_current        <= usb_current;
            item_reg.reverse_connected  <= reverse_connected;
            item_reg.supply_24v_present <= supply_24v_present;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid         = out_vld_reg;
    assign battery_status    = res_reg.battery_status;
    assign input_status      = res_reg.input_status[1:0];
    assign usb_status        = res_reg.usb_status;
    assign battery_class     = res_reg.battery_class;
    assign relay_on          = res_reg.relay_on;
    assign supply_from_24v   = res_reg.supply_from_24v;
    assign charge_full_start = res_reg.charge_full_start;

`ifndef SYNTHESIS
    // The full pulse is given once; its flag never drops.
    a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.full_seen |=> state_reg.full_seen)
        else $error("charge-full flag cleared after being set");

    // Once the class is latched it never changes.
    a_class_locked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.latched_class != bcsc_pkg::CLASS_UNKNOWN) |=> $stable(state_reg.latched_class))
        else $error("latched battery class changed");

    // A shown full pulse must already be recorded in the state.
    a_pulse_recorded: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && res_reg.charge_full_start) |-> state_reg.full_seen)
        else $error("full pulse shown without the full flag set");

    // The relay can only be on while the input is charging or repair charging.
    a_relay_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && res_reg.relay_on) |->
            (res_reg.input_status == bcsc_pkg::IS_CHARGE
             || res_reg.input_status == bcsc_pkg::IS_FIX))
        else $error("relay on without a charging input status");
`endif

endmodule

`default_nettype wire
